// ===== src/tsac_pkg.sv =====
// ----------------------------------------------------------------------------
// tsac_pkg
// shared types and constants for the three-sensor agreement check
// ----------------------------------------------------------------------------
package tsac_pkg;

    localparam int TEMP_W  = 15;
    localparam int DIFF_W  = TEMP_W + 1;
    localparam logic [TEMP_W-1:0] THR_RESET = TEMP_W'(200);

    typedef enum logic [1:0] {
        SUS_NONE = 2'd0,
        SUS_A    = 2'd1,
        SUS_B    = 2'd2,
        SUS_C    = 2'd3
    } t_suspect;

    // stage 2: magnitudes and ordering flags
    typedef struct packed {
        logic [TEMP_W-1:0] dab;
        logic [TEMP_W-1:0] dac;
        logic [TEMP_W-1:0] dbc;
        logic              ge_ab;
        logic              le_ab;
        logic              ge_ac;
        logic              le_ac;
        logic              ge_bc;
        logic              le_bc;
        logic              va;
        logic              vb;
        logic              vc;
    } t_s2;

    // stage 3: masked deltas, maximum and distances to the median
    typedef struct packed {
        logic [TEMP_W-1:0] dab;
        logic [TEMP_W-1:0] dac;
        logic [TEMP_W-1:0] mx;
        logic [TEMP_W-1:0] ea;
        logic [TEMP_W-1:0] eb;
        logic [TEMP_W-1:0] ec;
        logic              vab;
        logic              vac;
        logic              vbc;
        logic              any;
        logic              all3;
    } t_s3;

endpackage

// ===== src/tsac_vote.sv =====
// ----------------------------------------------------------------------------
// tsac_vote
// valid masking, pairwise maximum and distances of each sensor to the median
// ----------------------------------------------------------------------------
module tsac_vote (
    input  tsac_pkg::t_s2 i_s2,
    output tsac_pkg::t_s3 o_s3
);

    logic                       vab;
    logic                       vac;
    logic                       vbc;
    logic                       med_a;
    logic                       med_b;
    logic [tsac_pkg::TEMP_W-1:0] dab_m;
    logic [tsac_pkg::TEMP_W-1:0] dac_m;
    logic [tsac_pkg::TEMP_W-1:0] dbc_m;
    logic [tsac_pkg::TEMP_W-1:0] mx_1;

    assign vab = i_s2.va && i_s2.vb;
    assign vac = i_s2.va && i_s2.vc;
    assign vbc = i_s2.vb && i_s2.vc;

    assign dab_m = vab ? i_s2.dab : '0;
    assign dac_m = vac ? i_s2.dac : '0;
    assign dbc_m = vbc ? i_s2.dbc : '0;

    // median by value; ties give the same median value
    assign med_a = (i_s2.ge_ab && i_s2.le_ac) || (i_s2.le_ab && i_s2.ge_ac);
    assign med_b = (i_s2.le_ab && i_s2.le_bc) || (i_s2.ge_ab && i_s2.ge_bc);

    assign mx_1 = (dab_m > dac_m) ? dab_m : dac_m;

    always_comb begin
        o_s3.dab  = dab_m;
        o_s3.dac  = dac_m;
        o_s3.mx   = (dbc_m > mx_1) ? dbc_m : mx_1;
        o_s3.vab  = vab;
        o_s3.vac  = vac;
        o_s3.vbc  = vbc;
        o_s3.any  = i_s2.va || i_s2.vb || i_s2.vc;
        o_s3.all3 = i_s2.va && i_s2.vb && i_s2.vc;
        if (med_a) begin
            o_s3.ea = '0;
            o_s3.eb = i_s2.dab;
            o_s3.ec = i_s2.dac;
        end else if (med_b) begin
            o_s3.ea = i_s2.dab;
            o_s3.eb = '0;
            o_s3.ec = i_s2.dbc;
        end else begin
            o_s3.ea = i_s2.dac;
            o_s3.eb = i_s2.dbc;
            o_s3.ec = '0;
        end
    end

endmodule

// ===== src/triple_sensor_agreement_check_core.sv =====
// ----------------------------------------------------------------------------
// triple_sensor_agreement_check_core
// four register stages: differences, magnitudes, vote and results; a request
// passes through them in that order on its way to the outputs
// throughput: one request per cycle while the output does not stall
// an empty stage is filled even while the output waits; o_stall only when full
// reset (synchronous, active low) empties the pipeline and sets threshold 200
// ----------------------------------------------------------------------------
module triple_sensor_agreement_check_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic        [tsac_pkg::TEMP_W-1:0] i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [tsac_pkg::TEMP_W-1:0] i_temp_a,
    input  logic                              i_valid_a,
    input  logic signed [tsac_pkg::TEMP_W-1:0] i_temp_b,
    input  logic                              i_valid_b,
    input  logic signed [tsac_pkg::TEMP_W-1:0] i_temp_c,
    input  logic                              i_valid_c,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic        [tsac_pkg::TEMP_W-1:0] o_delta_ab,
    output logic                              o_delta_ab_valid,
    output logic        [tsac_pkg::TEMP_W-1:0] o_delta_ac,
    output logic                              o_delta_ac_valid,
    output logic        [tsac_pkg::TEMP_W-1:0] o_max_delta,
    output logic                              o_max_delta_valid,
    output logic                              o_disagree,
    output logic        [1:0]                 o_suspect
);

    logic [tsac_pkg::TEMP_W-1:0] r_thr;

    logic r_vld1;
    logic r_vld2;
    logic r_vld3;
    logic r_vld4;
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    // stage 1: signed differences
    logic [tsac_pkg::DIFF_W-1:0] r_d_ab;
    logic [tsac_pkg::DIFF_W-1:0] r_d_ac;
    logic [tsac_pkg::DIFF_W-1:0] r_d_bc;
    logic                        r_va;
    logic                        r_vb;
    logic                        r_vc;
    logic [tsac_pkg::DIFF_W-1:0] n_d_ab;
    logic [tsac_pkg::DIFF_W-1:0] n_d_ac;
    logic [tsac_pkg::DIFF_W-1:0] n_d_bc;

    // stage 2 and 3
    tsac_pkg::t_s2 r_s2;
    tsac_pkg::t_s2 n_s2;
    tsac_pkg::t_s3 r_s3;
    tsac_pkg::t_s3 n_s3;

    // stage 4: results
    logic [tsac_pkg::TEMP_W-1:0] r_dab;
    logic                        r_vab;
    logic [tsac_pkg::TEMP_W-1:0] r_dac;
    logic                        r_vac;
    logic [tsac_pkg::TEMP_W-1:0] r_mx;
    logic                        r_any;
    logic                        r_dis;
    tsac_pkg::t_suspect          r_sus;
    logic                        n_dis;
    tsac_pkg::t_suspect          n_sus;

    assign en4 = !r_vld4 || !i_stall;
    assign en3 = !r_vld3 || en4;
    assign en2 = !r_vld2 || en3;
    assign en1 = !r_vld1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= tsac_pkg::THR_RESET;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
            if (en3) begin
                r_vld3 <= r_vld2;
            end
            if (en4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    // stage 1
    assign n_d_ab = {i_temp_a[tsac_pkg::TEMP_W-1], i_temp_a}
                  - {i_temp_b[tsac_pkg::TEMP_W-1], i_temp_b};
    assign n_d_ac = {i_temp_a[tsac_pkg::TEMP_W-1], i_temp_a}
                  - {i_temp_c[tsac_pkg::TEMP_W-1], i_temp_c};
    assign n_d_bc = {i_temp_b[tsac_pkg::TEMP_W-1], i_temp_b}
                  - {i_temp_c[tsac_pkg::TEMP_W-1], i_temp_c};

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_d_ab <= n_d_ab;
            r_d_ac <= n_d_ac;
            r_d_bc <= n_d_bc;
            r_va   <= i_valid_a;
            r_vb   <= i_valid_b;
            r_vc   <= i_valid_c;
        end
    end

    // stage 2
    always_comb begin
        logic [tsac_pkg::DIFF_W-1:0] abs_ab;
        logic [tsac_pkg::DIFF_W-1:0] abs_ac;
        logic [tsac_pkg::DIFF_W-1:0] abs_bc;
        abs_ab = r_d_ab[tsac_pkg::DIFF_W-1] ? -r_d_ab : r_d_ab;
        abs_ac = r_d_ac[tsac_pkg::DIFF_W-1] ? -r_d_ac : r_d_ac;
        abs_bc = r_d_bc[tsac_pkg::DIFF_W-1] ? -r_d_bc : r_d_bc;
        n_s2.dab   = abs_ab[tsac_pkg::TEMP_W-1:0];
        n_s2.dac   = abs_ac[tsac_pkg::TEMP_W-1:0];
        n_s2.dbc   = abs_bc[tsac_pkg::TEMP_W-1:0];
        n_s2.ge_ab = !r_d_ab[tsac_pkg::DIFF_W-1];
        n_s2.le_ab = r_d_ab[tsac_pkg::DIFF_W-1] || (r_d_ab == '0);
        n_s2.ge_ac = !r_d_ac[tsac_pkg::DIFF_W-1];
        n_s2.le_ac = r_d_ac[tsac_pkg::DIFF_W-1] || (r_d_ac == '0);
        n_s2.ge_bc = !r_d_bc[tsac_pkg::DIFF_W-1];
        n_s2.le_bc = r_d_bc[tsac_pkg::DIFF_W-1] || (r_d_bc == '0);
        n_s2.va    = r_va;
        n_s2.vb    = r_vb;
        n_s2.vc    = r_vc;
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_vld1) begin
            r_s2 <= n_s2;
        end
    end

    // stage 3
    tsac_vote u_vote (
        .i_s2 (r_s2),
        .o_s3 (n_s3)
    );

    always_ff @(posedge i_clk) begin
        if (en3 && r_vld2) begin
            r_s3 <= n_s3;
        end
    end

    // stage 4
    assign n_dis = r_s3.any && (r_s3.mx > r_thr);

    always_comb begin
        n_sus = tsac_pkg::SUS_NONE;
        if (n_dis) begin
            if (r_s3.all3) begin
                if (r_s3.ea >= r_s3.eb && r_s3.ea >= r_s3.ec) begin
                    n_sus = tsac_pkg::SUS_A;
                end else if (r_s3.eb >= r_s3.ec) begin
                    n_sus = tsac_pkg::SUS_B;
                end else begin
                    n_sus = tsac_pkg::SUS_C;
                end
            end else if (r_s3.vab || r_s3.vac) begin
                n_sus = tsac_pkg::SUS_A;
            end else if (r_s3.vbc) begin
                n_sus = tsac_pkg::SUS_B;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_vld3) begin
            r_dab <= r_s3.dab;
            r_vab <= r_s3.vab;
            r_dac <= r_s3.dac;
            r_vac <= r_s3.vac;
            r_mx  <= r_s3.mx;
            r_any <= r_s3.any;
            r_dis <= n_dis;
            r_sus <= n_sus;
        end
    end

    assign o_valid           = r_vld4;
    assign o_delta_ab        = r_dab;
    assign o_delta_ab_valid  = r_vab;
    assign o_delta_ac        = r_dac;
    assign o_delta_ac_valid  = r_vac;
    assign o_max_delta       = r_mx;
    assign o_max_delta_valid = r_any;
    assign o_disagree        = r_dis;
    assign o_suspect         = r_sus;

    // suspect is named only on disagreement
    a_sus_needs_dis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_suspect == tsac_pkg::SUS_NONE) || o_disagree)
        else $error("suspect without disagreement");

    // no valid sensor gives an empty result
    a_none_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_max_delta_valid) |->
            !o_disagree && (o_max_delta == '0) && !o_delta_ab_valid)
        else $error("result from no valid sensor");

    // the maximum covers both reported deltas
    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_max_delta >= o_delta_ab) && (o_max_delta >= o_delta_ac))
        else $error("max delta below a pair delta");

    // the input side is held back only by a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall && o_valid)
        else $error("input stalled with output free");

    // pipeline empty after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result right after reset");

endmodule
